@@ rtl/core/rcp_pkg.sv @@
// Shared types, codes and default sizes for the rectangle canvas painter.
// Used by rectangle_canvas_painter_top; depends on nothing else.

package rcp_pkg;

    localparam int DEFAULT_MAX_WIDTH     = 256;
    localparam int DEFAULT_MAX_HEIGHT    = 256;
    localparam int DEFAULT_FRACTION_BITS = 8;

    localparam int COORD_W    = 24;
    localparam int BOUND_W    = COORD_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] TYPE_OUTLINE = 8'd114;
    localparam logic [7:0] TYPE_FILLED  = 8'd82;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REJECT  = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_CANVAS_WIDTH  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] RESET_CANVAS_HEIGHT = 9'd256;
    localparam logic [7:0]            RESET_BACKGROUND    = 8'd32;

    typedef struct packed {
        logic [1:0]                command;
        logic [7:0]                shape_type;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic [7:0]                draw_color;
        logic [7:0]                pixel_column;
        logic [7:0]                pixel_row;
    } cmd_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [1:0] status;
        logic       error_latched;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FILL,
        S_SETUP_XL,
        S_SETUP_XR,
        S_SETUP_YT,
        S_SETUP_YB,
        S_PAINT,
        S_RD_ISSUE,
        S_RD_TAKE,
        S_RESULT
    } state_t;

endpackage

@@ rtl/core/rcp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the canvas of rectangle_canvas_painter_top; depends on nothing else.

module rcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/rectangle_canvas_painter_top.sv @@
// Top level of the rectangle canvas painter: sequencer, shared bound adder and pixel sweep.
// Depends on rcp_pkg for types and codes and on rcp_ram for the canvas store.
//
// Channel  Direction  Signals                          Payload
// cmd      in         cmd_valid, cmd_ready, cmd        rcp_pkg::cmd_t
// rsp      out        rsp_valid, rsp_ready, rsp        rcp_pkg::rsp_t
// cfg      in         cfg_valid, cfg_ready, cfg_index  cfg_data (9 bits)
//
// A clear writes every canvas entry, one per cycle.
// A draw first sets the left, right, top and bottom bounds in turn on the shared adder, then
// sweeps the in-use area (width times height) pixel by pixel; an in-canvas read issues, then takes.
// A rejected or ignored draw and an unknown command go from idle straight to the result state.
// After reset the whole canvas is zeroed before cmd_ready rises.
// A command transaction is taken only while idle; a finished result waits for rsp_ready
// in the output register while the next command transaction may already be accepted.

module rectangle_canvas_painter_top #(
    parameter int MAX_WIDTH     = rcp_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT    = rcp_pkg::DEFAULT_MAX_HEIGHT,
    parameter int FRACTION_BITS = rcp_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  rcp_pkg::cmd_t                    cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output rcp_pkg::rsp_t                    rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int XW    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
    localparam int SWX   = $clog2(MAX_WIDTH + 1);
    localparam int SWY   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW  = (SWX > SWY ? SWX : SWY) > rcp_pkg::CFG_DATA_W
                           ? (SWX > SWY ? SWX : SWY) : rcp_pkg::CFG_DATA_W;
    localparam int EW    = rcp_pkg::BOUND_W;
    localparam int CW    = rcp_pkg::COORD_W;

    localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic signed [EW-1:0] ONE_M1 = EW'((1 << FRACTION_BITS) - 1);

    rcp_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                     addr_reg, addr_next;
    logic [AW-1:0]                     base_reg, base_next;
    logic [XW-1:0]                     col_reg, col_next;
    logic [YW-1:0]                     row_reg, row_next;
    rcp_pkg::cmd_t                     req_reg, req_next;
    logic [7:0]                        fill_reg, fill_next;
    logic signed [EW-1:0]              xl_reg, xl_next;
    logic signed [EW-1:0]              xr_reg, xr_next;
    logic signed [EW-1:0]              yt_reg, yt_next;
    logic signed [EW-1:0]              yb_reg, yb_next;
    logic                              error_reg, error_next;
    rcp_pkg::rsp_t                     res_reg, res_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    rcp_pkg::rsp_t                     rsp_reg, rsp_next;
    logic [rcp_pkg::CFG_DATA_W-1:0]    cfg_width_reg;
    logic [rcp_pkg::CFG_DATA_W-1:0]    cfg_height_reg;
    logic [7:0]                        cfg_bg_reg;

    logic [SWX-1:0]        eff_w;
    logic [SWY-1:0]        eff_h;
    logic [SWX-1:0]        w_last;
    logic [SWY-1:0]        h_last;
    logic                  read_outside;
    logic [AW+8:0]         read_addr_full;
    logic signed [EW-1:0]  add_a;
    logic signed [EW-1:0]  add_b;
    logic signed [EW-1:0]  add_sum;
    logic signed [EW-1:0]  add_shr;
    logic signed [EW-1:0]  col_s;
    logic signed [EW-1:0]  row_s;
    logic                  x_in;
    logic                  y_in;
    logic                  x_edge;
    logic                  y_edge;
    logic                  paint_hit;
    logic                  bad_shape;
    logic                  mem_we;
    logic [7:0]            mem_wdata;
    logic [7:0]            mem_rdata;

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == rcp_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= rcp_pkg::RESET_CANVAS_WIDTH;
            cfg_height_reg <= rcp_pkg::RESET_CANVAS_HEIGHT;
            cfg_bg_reg     <= rcp_pkg::RESET_BACKGROUND;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rcp_pkg::CFG_CANVAS_WIDTH:  cfg_width_reg  <= cfg_data;
                rcp_pkg::CFG_CANVAS_HEIGHT: cfg_height_reg <= cfg_data;
                rcp_pkg::CFG_BACKGROUND:    cfg_bg_reg     <= cfg_data[7:0];
                default:                    cfg_bg_reg     <= cfg_bg_reg;
            endcase
        end
    end

    // Sizes in use, saturated into one up to the maximum.
    always_comb
    begin
        if (cfg_width_reg == '0)
        begin
            eff_w = SWX'(1);
        end
        else if (CMPW'(cfg_width_reg) > CMPW'(MAX_WIDTH))
        begin
            eff_w = SWX'(MAX_WIDTH);
        end
        else
        begin
            eff_w = SWX'(cfg_width_reg);
        end
        if (cfg_height_reg == '0)
        begin
            eff_h = SWY'(1);
        end
        else if (CMPW'(cfg_height_reg) > CMPW'(MAX_HEIGHT))
        begin
            eff_h = SWY'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = SWY'(cfg_height_reg);
        end
        w_last = eff_w - SWX'(1);
        h_last = eff_h - SWY'(1);
    end

    assign read_outside = (CMPW'(cmd.pixel_column) >= CMPW'(eff_w))
                       || (CMPW'(cmd.pixel_row) >= CMPW'(eff_h));
    assign read_addr_full = (AW + 9)'(cmd.pixel_row) * (AW + 9)'(MAX_WIDTH)
                          + (AW + 9)'(cmd.pixel_column);

    assign bad_shape = cmd.rect_width[CW-1] || (cmd.rect_width == '0)
                    || cmd.rect_height[CW-1] || (cmd.rect_height == '0)
                    || ((cmd.shape_type != rcp_pkg::TYPE_OUTLINE)
                        && (cmd.shape_type != rcp_pkg::TYPE_FILLED));

    // Shared adder: the left and top edges are rounded up and the right and bottom edges down to whole pixels.
    always_comb
    begin
        case (state_reg)
            rcp_pkg::S_SETUP_XL:
            begin
                add_a = {{(EW - CW){req_reg.rect_x[CW-1]}}, req_reg.rect_x};
                add_b = ONE_M1;
            end
            rcp_pkg::S_SETUP_XR:
            begin
                add_a = {{(EW - CW){req_reg.rect_x[CW-1]}}, req_reg.rect_x};
                add_b = {{(EW - CW){req_reg.rect_width[CW-1]}}, req_reg.rect_width};
            end
            rcp_pkg::S_SETUP_YT:
            begin
                add_a = {{(EW - CW){req_reg.rect_y[CW-1]}}, req_reg.rect_y};
                add_b = ONE_M1;
            end
            default:
            begin
                add_a = {{(EW - CW){req_reg.rect_y[CW-1]}}, req_reg.rect_y};
                add_b = {{(EW - CW){req_reg.rect_height[CW-1]}}, req_reg.rect_height};
            end
        endcase
        add_sum = add_a + add_b;
        add_shr = add_sum >>> FRACTION_BITS;
    end

    assign col_s  = $signed({{(EW - XW){1'b0}}, col_reg});
    assign row_s  = $signed({{(EW - YW){1'b0}}, row_reg});
    assign x_in   = (col_s >= xl_reg) && (col_s <= xr_reg);
    assign y_in   = (row_s >= yt_reg) && (row_s <= yb_reg);
    assign x_edge = (col_s == xl_reg) || (col_s == xr_reg);
    assign y_edge = (row_s == yt_reg) || (row_s == yb_reg);
    assign paint_hit = x_in && y_in
                    && ((req_reg.shape_type == rcp_pkg::TYPE_FILLED) || x_edge || y_edge);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        req_next       = req_reg;
        fill_next      = fill_reg;
        xl_next        = xl_reg;
        xr_next        = xr_reg;
        yt_next        = yt_reg;
        yb_next        = yb_reg;
        error_next     = error_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_wdata      = fill_reg;

        case (state_reg)
            rcp_pkg::S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = rcp_pkg::S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            rcp_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    req_next = cmd;
                    res_next = '{pixel_value: '0, status: rcp_pkg::STATUS_OK,
                                 error_latched: error_reg};
                    case (cmd.command)
                        rcp_pkg::CMD_CLEAR:
                        begin
                            error_next             = 1'b0;
                            res_next.error_latched = 1'b0;
                            fill_next              = cfg_bg_reg;
                            addr_next              = '0;
                            state_next             = rcp_pkg::S_FILL;
                        end
                        rcp_pkg::CMD_DRAW:
                        begin
                            if (error_reg || bad_shape)
                            begin
                                error_next             = 1'b1;
                                res_next.status        = rcp_pkg::STATUS_REJECT;
                                res_next.error_latched = 1'b1;
                                state_next             = rcp_pkg::S_RESULT;
                            end
                            else
                            begin
                                fill_next  = cmd.draw_color;
                                addr_next  = '0;
                                base_next  = '0;
                                col_next   = '0;
                                row_next   = '0;
                                state_next = rcp_pkg::S_SETUP_XL;
                            end
                        end
                        rcp_pkg::CMD_READ:
                        begin
                            if (read_outside)
                            begin
                                res_next.status = rcp_pkg::STATUS_OUTSIDE;
                                state_next      = rcp_pkg::S_RESULT;
                            end
                            else
                            begin
                                addr_next  = read_addr_full[AW-1:0];
                                state_next = rcp_pkg::S_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = rcp_pkg::S_RESULT;
                        end
                    endcase
                end
            end
            rcp_pkg::S_FILL:
            begin
                mem_we = 1'b1;
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = rcp_pkg::S_RESULT;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            rcp_pkg::S_SETUP_XL:
            begin
                xl_next    = add_shr;
                state_next = rcp_pkg::S_SETUP_XR;
            end
            rcp_pkg::S_SETUP_XR:
            begin
                xr_next    = add_shr;
                state_next = rcp_pkg::S_SETUP_YT;
            end
            rcp_pkg::S_SETUP_YT:
            begin
                yt_next    = add_shr;
                state_next = rcp_pkg::S_SETUP_YB;
            end
            rcp_pkg::S_SETUP_YB:
            begin
                yb_next    = add_shr;
                state_next = rcp_pkg::S_PAINT;
            end
            rcp_pkg::S_PAINT:
            begin
                mem_we = paint_hit;
                if (col_reg == w_last[XW-1:0])
                begin
                    if (row_reg == h_last[YW-1:0])
                    begin
                        state_next = rcp_pkg::S_RESULT;
                    end
                    else
                    begin
                        col_next  = '0;
                        row_next  = row_reg + YW'(1);
                        base_next = base_reg + ROW_STRIDE;
                        addr_next = base_reg + ROW_STRIDE;
                    end
                end
                else
                begin
                    col_next  = col_reg + XW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            rcp_pkg::S_RD_ISSUE:
            begin
                state_next = rcp_pkg::S_RD_TAKE;
            end
            rcp_pkg::S_RD_TAKE:
            begin
                res_next.pixel_value = mem_rdata;
                state_next           = rcp_pkg::S_RESULT;
            end
            rcp_pkg::S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = rcp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rcp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcp_pkg::S_INIT;
            addr_reg      <= '0;
            base_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            error_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            base_reg      <= base_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            error_reg     <= error_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        fill_reg <= fill_next;
        xl_reg   <= xl_next;
        xr_reg   <= xr_next;
        yt_reg   <= yt_next;
        yb_reg   <= yb_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    rcp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (addr_reg),
        .wr_data (mem_wdata),
        .rd_addr (addr_reg),
        .rd_data (mem_rdata)
    );

    // The sweep address must always equal the row base plus the column.
    a_paint_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcp_pkg::S_PAINT) |-> (addr_reg == base_reg + AW'(col_reg)))
        else $error("Paint address is out of step with row and column.");

    // Nothing is painted while the error flag is latched.
    a_no_paint_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcp_pkg::S_PAINT) |-> !error_reg)
        else $error("Paint sweep runs with the error flag set.");

    // A clear drops the error flag for the whole sweep.
    a_fill_clears_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcp_pkg::S_FILL) |-> !error_reg)
        else $error("Error flag set during a clear.");

    // The canvas is written only by the clearing sweeps and the paint sweep.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == rcp_pkg::S_INIT || state_reg == rcp_pkg::S_FILL
                    || state_reg == rcp_pkg::S_PAINT))
        else $error("Canvas written outside a sweep.");

    // A read outside the canvas returns a zero pixel.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == rcp_pkg::STATUS_OUTSIDE) |-> (rsp.pixel_value == '0))
        else $error("Read outside the canvas returned a nonzero pixel.");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rectangle_canvas_painter_top: a directed table, then random traffic.
// A behavioral canvas model predicts each response the table does not fix. Depends on rcp_pkg and the RTL top level.

module tb_top;
    import rcp_pkg::*;

    localparam int CANVAS_COLS = DEFAULT_MAX_WIDTH;
    localparam int CANVAS_ROWS = DEFAULT_MAX_HEIGHT;
    localparam int UNIT = 1 << DEFAULT_FRACTION_BITS;
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int MAX_GAP = 17;
    localparam int RANDOM_ITEMS = 75;
    localparam int RANDOM_PHASES = 5;
    localparam int RANDOM_CLEARS = 4;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam rsp_t NO_WANT = '0;

    typedef struct {
        cmd_t item;
        bit   fixed;
        rsp_t want;
        bit   shrink;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [7:0]            shadow_pixels [CANVAS_COLS * CANVAS_ROWS];
    bit                    shadow_error;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [7:0]            background_reg;
    rsp_t                  pending_responses [$];
    int                    burst_left [2];
    int                    failures;
    int                    clears_left;
    int                    commands_sent;
    int                    painted_draws;
    int                    refused_draws;
    int                    reads_served;
    int                    settings_used;

    rectangle_canvas_painter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int next_gap(int side);
        if (burst_left[side] > 0)
        begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            burst_left[side] = $urandom_range(4, 12);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic int effective_size(logic [CFG_DATA_W-1:0] setting, int limit);
        if (setting == '0)
        begin
            return 1;
        end
        if (int'(setting) > limit)
        begin
            return limit;
        end
        return int'(setting);
    endfunction

    function automatic rsp_t response(logic [7:0] pixel, logic [1:0] code, logic flag);
        rsp_t r;
        r.pixel_value   = pixel;
        r.status        = code;
        r.error_latched = flag;
        return r;
    endfunction

    function automatic cmd_t build_cmd(logic [1:0] op, logic [7:0] shape, int x, int y,
                                       int w, int h, logic [7:0] color, int col, int row);
        cmd_t c;
        c.command      = op;
        c.shape_type   = shape;
        c.rect_x       = 24'(x);
        c.rect_y       = 24'(y);
        c.rect_width   = 24'(w);
        c.rect_height  = 24'(h);
        c.draw_color   = color;
        c.pixel_column = 8'(col);
        c.pixel_row    = 8'(row);
        return c;
    endfunction

    function automatic rsp_t canvas_response(cmd_t c);
        rsp_t r;
        int   cols;
        int   rows;
        int   left;
        int   top;
        int   right;
        int   bottom;
        int   wdt;
        int   hgt;
        int   px;
        int   py;
        bit   near_edge;
        r      = '0;
        cols   = effective_size(width_reg, CANVAS_COLS);
        rows   = effective_size(height_reg, CANVAS_ROWS);
        left   = int'($signed(c.rect_x));
        top    = int'($signed(c.rect_y));
        wdt    = int'($signed(c.rect_width));
        hgt    = int'($signed(c.rect_height));
        right  = left + wdt;
        bottom = top + hgt;
        case (c.command)
            CMD_CLEAR:
            begin
                foreach (shadow_pixels[i])
                begin
                    shadow_pixels[i] = background_reg;
                end
                shadow_error = 1'b0;
            end
            CMD_DRAW:
            begin
                if (shadow_error)
                begin
                    r.status = STATUS_REJECT;
                    refused_draws++;
                end
                else if (wdt <= 0 || hgt <= 0 ||
                         (c.shape_type != TYPE_OUTLINE && c.shape_type != TYPE_FILLED))
                begin
                    shadow_error = 1'b1;
                    r.status = STATUS_REJECT;
                    refused_draws++;
                end
                else
                begin
                    painted_draws++;
                    for (int row = 0; row < rows; row++)
                    begin
                        for (int col = 0; col < cols; col++)
                        begin
                            px = col * UNIT;
                            py = row * UNIT;
                            if (px >= left && px <= right && py >= top && py <= bottom)
                            begin
                                near_edge = (px - left < UNIT) || (right - px < UNIT) ||
                                            (py - top < UNIT) || (bottom - py < UNIT);
                                if (c.shape_type == TYPE_FILLED || near_edge)
                                begin
                                    shadow_pixels[row * CANVAS_COLS + col] = c.draw_color;
                                end
                            end
                        end
                    end
                end
            end
            CMD_READ:
            begin
                if (int'(c.pixel_column) >= cols || int'(c.pixel_row) >= rows)
                begin
                    r.status = STATUS_OUTSIDE;
                end
                else
                begin
                    r.pixel_value = shadow_pixels[int'(c.pixel_row) * CANVAS_COLS +
                                                  int'(c.pixel_column)];
                    reads_served++;
                end
            end
            default:
            begin
            end
        endcase
        r.error_latched = shadow_error;
        return r;
    endfunction

    function automatic cmd_t random_command(int cols, int rows);
        cmd_t c;
        int   pick;
        int   col_limit;
        int   row_limit;
        c = build_cmd(CMD_SPARE, 8'($urandom), int'($urandom), int'($urandom),
                      int'($urandom), int'($urandom), 8'($urandom),
                      int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
        col_limit = (cols > 255) ? 255 : cols;
        row_limit = (rows > 255) ? 255 : rows;
        pick = $urandom_range(0, 99);
        if (shadow_error && clears_left > 0 && pick < 30)
        begin
            c.command = CMD_CLEAR;
            clears_left--;
        end
        else if (pick < 5)
        begin
            c.command = CMD_SPARE;
        end
        else if (pick < 50)
        begin
            c.command = CMD_READ;
            if ($urandom_range(0, 3) != 0)
            begin
                c.pixel_column = 8'($urandom_range(0, col_limit));
                c.pixel_row    = 8'($urandom_range(0, row_limit));
            end
        end
        else
        begin
            c.command     = CMD_DRAW;
            c.shape_type  = ($urandom_range(0, 1) != 0) ? TYPE_FILLED : TYPE_OUTLINE;
            c.rect_x      = 24'(int'($urandom_range(0, (cols + 4) * UNIT)) - 3 * UNIT);
            c.rect_y      = 24'(int'($urandom_range(0, (rows + 4) * UNIT)) - 3 * UNIT);
            c.rect_width  = 24'($urandom_range(1, (cols + 3) * UNIT));
            c.rect_height = 24'($urandom_range(1, (rows + 3) * UNIT));
            if ($urandom_range(0, 4) == 0)
            begin
                c.rect_width = 24'($urandom_range(1, UNIT + UNIT / 2));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                c.rect_height = 24'($urandom_range(1, UNIT + UNIT / 2));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                c.rect_x      = 24'($urandom);
                c.rect_y      = 24'($urandom);
                c.rect_width  = 24'($urandom_range(1, COORD_MAX));
                c.rect_height = 24'($urandom_range(1, COORD_MAX));
            end
            if (clears_left > 0 && $urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: c.rect_width = 24'(-int'($urandom_range(0, -COORD_MIN)));
                    1: c.rect_height = 24'(-int'($urandom_range(0, -COORD_MIN)));
                    default:
                    begin
                        do
                        begin
                            c.shape_type = 8'($urandom);
                        end
                        while (c.shape_type == TYPE_FILLED || c.shape_type == TYPE_OUTLINE);
                    end
                endcase
            end
        end
        return c;
    endfunction

    task automatic send_command(cmd_t item, bit fixed, rsp_t want);
        int   gap;
        rsp_t predicted;
        gap = next_gap(0);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        predicted = canvas_response(item);
        pending_responses.push_back(fixed ? want : predicted);
        commands_sent++;
        @(negedge clk);
    endtask

    task automatic drain_responses();
        cmd_valid <= 1'b0;
        while (pending_responses.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic configure(int cols, int rows, int shade);
        logic [CFG_IDX_W-1:0]  slots [4];
        logic [CFG_DATA_W-1:0] values [4];
        slots  = '{CFG_CANVAS_WIDTH, CFG_CANVAS_HEIGHT, CFG_BACKGROUND, CFG_UNUSED};
        values = '{9'(cols), 9'(rows), 9'(shade), 9'($urandom)};
        drain_responses();
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= slots[k];
            cfg_data  <= values[k];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            case (slots[k])
                CFG_CANVAS_WIDTH:  width_reg = values[k];
                CFG_CANVAS_HEIGHT: height_reg = values[k];
                CFG_BACKGROUND:    background_reg = values[k][7:0];
                default:
                begin
                end
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int   stall;
        rsp_t want;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = next_gap(1);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
            begin
                @(posedge clk);
            end
            if (pending_responses.size() == 0)
            begin
                $error("response transaction with nothing expected: pixel_value %0d, status %0d",
                       rsp.pixel_value, rsp.status);
                failures++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (rsp.pixel_value !== want.pixel_value)
                begin
                    $error("pixel_value: expected %0d, actual %0d",
                           want.pixel_value, rsp.pixel_value);
                    failures++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    failures++;
                end
                if (rsp.error_latched !== want.error_latched)
                begin
                    $error("error_latched: expected %0d, actual %0d",
                           want.error_latched, rsp.error_latched);
                    failures++;
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        stim_row_t directed [$];
        int        phase_cols [RANDOM_PHASES];
        int        phase_rows [RANDOM_PHASES];
        int        phase_shade [RANDOM_PHASES];
        int        cols;
        int        rows;

        phase_cols  = '{1, 0, 511, 20, 256};
        phase_rows  = '{1, 511, 3, 16, 9};
        phase_shade = '{0, 511, 128, 300, 255};
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        foreach (shadow_pixels[i])
        begin
            shadow_pixels[i] = 8'd0;
        end
        shadow_error   = 1'b0;
        width_reg      = RESET_CANVAS_WIDTH;
        height_reg     = RESET_CANVAS_HEIGHT;
        background_reg = RESET_BACKGROUND;
        burst_left     = '{0, 0};
        failures       = 0;
        clears_left    = RANDOM_CLEARS;
        commands_sent  = 0;
        painted_draws  = 0;
        refused_draws  = 0;
        reads_served   = 0;
        settings_used  = 1;

        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0),
                             1'b1, response(8'd0, STATUS_OK, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 255, 255),
                             1'b1, response(8'd0, STATUS_OK, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_SPARE, 8'hFF, COORD_MAX, COORD_MIN, COORD_MAX,
                                       COORD_MIN, 8'hFF, 255, 255),
                             1'b1, response(8'd0, STATUS_OK, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_FILLED, 0, 0, 0, 4 * UNIT, 8'hEE, 0, 0),
                             1'b1, response(8'd0, STATUS_REJECT, 1'b1), 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_OUTLINE, 0, 0, 5 * UNIT, 5 * UNIT,
                                       8'h5A, 0, 0),
                             1'b1, response(8'd0, STATUS_REJECT, 1'b1), 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0),
                             1'b1, response(8'd0, STATUS_OK, 1'b1), 1'b0});
        directed.push_back('{build_cmd(CMD_CLEAR, TYPE_FILLED, UNIT, UNIT, UNIT, UNIT,
                                       8'h44, 7, 7),
                             1'b1, response(8'd0, STATUS_OK, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 200, 100),
                             1'b1, response(RESET_BACKGROUND, STATUS_OK, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_FILLED, -UNIT - UNIT / 2, UNIT / 4,
                                       COORD_MAX, COORD_MAX, 8'hA5, 0, 0),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 255, 255),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0),
                             1'b1, response(8'd0, STATUS_OK, 1'b0), 1'b1});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 15, 11),
                             1'b1, response(8'hC5, STATUS_OK, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 16, 0),
                             1'b1, response(8'd0, STATUS_OUTSIDE, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 12),
                             1'b1, response(8'd0, STATUS_OUTSIDE, 1'b0), 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_FILLED, 2 * UNIT + UNIT / 2, UNIT,
                                       4 * UNIT, 3 * UNIT + UNIT / 2, 8'h11, 0, 0),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_OUTLINE, 3 * UNIT, 2 * UNIT, 10 * UNIT,
                                       8 * UNIT, 8'h77, 0, 0),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_OUTLINE, 8 * UNIT, 8 * UNIT, 1,
                                       2 * UNIT, 8'h3C, 0, 0),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_FILLED, COORD_MIN, -UNIT, COORD_MAX,
                                       COORD_MAX, 8'h96, 0, 0),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 3, 2),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8, 9),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 5, 5),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, 8'hFF, UNIT, UNIT, 2 * UNIT, 2 * UNIT,
                                       8'h0F, 0, 0),
                             1'b1, response(8'd0, STATUS_REJECT, 1'b1), 1'b0});
        directed.push_back('{build_cmd(CMD_READ, 8'h00, 0, 0, 0, 0, 8'h00, 3, 2),
                             1'b0, NO_WANT, 1'b0});
        directed.push_back('{build_cmd(CMD_DRAW, TYPE_FILLED, 0, 0, 2 * UNIT, 2 * UNIT,
                                       8'hF0, 0, 0),
                             1'b1, response(8'd0, STATUS_REJECT, 1'b1), 1'b0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].shrink)
            begin
                configure(16, 12, 9'h1C5);
            end
            send_command(directed[i].item, directed[i].fixed, directed[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            configure(phase_cols[p], phase_rows[p], phase_shade[p]);
            cols = effective_size(width_reg, CANVAS_COLS);
            rows = effective_size(height_reg, CANVAS_ROWS);
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
            begin
                send_command(random_command(cols, rows), 1'b0, NO_WANT);
            end
        end

        drain_responses();
        repeat (20) @(negedge clk);
        $display("Ran %0d command transactions over %0d canvas settings.",
                 commands_sent, settings_used);
        $display("Draws painted: %0d, draws refused or ignored: %0d, in-canvas reads: %0d.",
                 painted_draws, refused_draws, reads_served);
        if (failures == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
